### design/sphr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the solenoid pulse/hold/release driver
package sphr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DUTY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DUTY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT  = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0] RST_PWM_PERIOD     = 16'd800;
  localparam logic [CFG_W-1:0] RST_PULSE_DUTY     = 16'd400;
  localparam logic [CFG_W-1:0] RST_HOLD_DUTY      = 16'd200;
  localparam logic [CFG_W-1:0] RST_RELEASE_DUTY   = 16'd100;
  localparam logic [CFG_W-1:0] RST_PULSE_LENGTH   = 16'd25000;
  localparam logic [CFG_W-1:0] RST_RELEASE_LENGTH = 16'd10000;
  localparam logic [CFG_W-1:0] RST_TIMEOUT_LIMIT  = 16'd6900;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PULSE   = 3'd1,
    PH_HOLD    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_TIMEOUT = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] request;
    logic       slow_tick;
  } in_word_t;

  typedef struct packed {
    logic [7:0] drive;
    logic [2:0] phase;
  } out_word_t;

endpackage

### design/solenoid_pulse_hold_release.sv
`timescale 1ns / 1ps
// peak-and-hold solenoid driver: phase decision, pwm compare and counters
// an accepted word's result appears in the output register in the cycle after it is accepted
// throughput: one word per cycle while the output is not stalled; the single output register sets this, and a
// word is still taken while the held result is being read out
// reset: synchronous, clears all counters, the held pattern and the output
// valid, and loads the configuration registers with their default values
module solenoid_pulse_hold_release
  import sphr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [15:0] pwm_period, pulse_duty, hold_duty, release_duty;
  logic [15:0] pulse_length, release_length, timeout_limit;

  // state
  logic [15:0] pwm_position, pwm_position_next;
  logic [7:0]  held_pattern, held_pattern_next;
  logic [15:0] pulse_count, pulse_count_next;
  logic [15:0] release_count, release_count_next;
  logic        release_active, release_active_next;
  logic [15:0] timeout_count, timeout_count_next;
  logic        timeout_enabled, timeout_enabled_next;

  logic        accept;
  phase_t      phase_c;
  logic [7:0]  drive_c;
  logic [15:0] tc_mid;
  logic [15:0] rc_start;
  logic [15:0] rc_dec;
  logic [16:0] pos_inc;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period     <= RST_PWM_PERIOD;
      pulse_duty     <= RST_PULSE_DUTY;
      hold_duty      <= RST_HOLD_DUTY;
      release_duty   <= RST_RELEASE_DUTY;
      pulse_length   <= RST_PULSE_LENGTH;
      release_length <= RST_RELEASE_LENGTH;
      timeout_limit  <= RST_TIMEOUT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD:     pwm_period     <= cfg_data;
        REG_PULSE_DUTY:     pulse_duty     <= cfg_data;
        REG_HOLD_DUTY:      hold_duty      <= cfg_data;
        REG_RELEASE_DUTY:   release_duty   <= cfg_data;
        REG_PULSE_LENGTH:   pulse_length   <= cfg_data;
        REG_RELEASE_LENGTH: release_length <= cfg_data;
        REG_TIMEOUT_LIMIT:  timeout_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_c              = PH_IDLE;
    drive_c              = 8'd0;
    held_pattern_next    = held_pattern;
    pulse_count_next     = pulse_count;
    release_count_next   = release_count;
    release_active_next  = release_active;
    timeout_enabled_next = timeout_enabled;
    tc_mid               = timeout_count;
    rc_start             = release_active ? release_count : release_length;
    rc_dec               = rc_start - 16'd1;

    if (in_data.request != 8'd0 && timeout_count >= timeout_limit) begin
      phase_c              = PH_TIMEOUT;
      timeout_enabled_next = 1'b0;
      held_pattern_next    = 8'd0;
    end else if (in_data.request == 8'd0 && held_pattern == 8'd0) begin
      phase_c              = PH_IDLE;
      timeout_enabled_next = 1'b0;
      tc_mid               = 16'd0;
    end else if (in_data.request == held_pattern) begin
      phase_c = PH_HOLD;
      if (pwm_position < hold_duty) begin
        drive_c = in_data.request;
      end
    end else if (in_data.request != 8'd0) begin
      phase_c              = PH_PULSE;
      timeout_enabled_next = 1'b1;
      if (pulse_count < pulse_length) begin
        // counting only runs in the off part of the period
        if (pwm_position < pulse_duty) begin
          drive_c = in_data.request;
        end else begin
          pulse_count_next = pulse_count + 16'd1;
        end
      end else begin
        held_pattern_next = in_data.request;
        pulse_count_next  = 16'd0;
      end
    end else begin
      phase_c = PH_RELEASE;
      if (rc_dec == 16'd0) begin
        release_active_next = 1'b0;
        release_count_next  = rc_dec;
        held_pattern_next   = 8'd0;
      end else begin
        release_active_next = 1'b1;
        release_count_next  = rc_dec;
        if (pwm_position < release_duty) begin
          drive_c = held_pattern;
        end
      end
    end

    // saturating timeout, gated by the enable as left by this word
    timeout_count_next = tc_mid;
    if (in_data.slow_tick && timeout_enabled_next) begin
      if (tc_mid < timeout_limit) begin
        timeout_count_next = tc_mid + 16'd1;
      end else begin
        timeout_count_next = timeout_limit;
      end
    end

    pos_inc           = {1'b0, pwm_position} + 17'd1;
    pwm_position_next = (pos_inc >= {1'b0, pwm_period}) ? 16'd0 : pos_inc[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_position    <= '0;
      held_pattern    <= '0;
      pulse_count     <= '0;
      release_count   <= '0;
      release_active  <= 1'b0;
      timeout_count   <= '0;
      timeout_enabled <= 1'b0;
    end else if (accept) begin
      pwm_position    <= pwm_position_next;
      held_pattern    <= held_pattern_next;
      pulse_count     <= pulse_count_next;
      release_count   <= release_count_next;
      release_active  <= release_active_next;
      timeout_count   <= timeout_count_next;
      timeout_enabled <= timeout_enabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.drive <= drive_c;
      out_data.phase <= phase_c;
    end
  end

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_timeout_disables: assert property (@(posedge clk) disable iff (rst)
    (accept && phase_c == PH_TIMEOUT) |=> (!timeout_enabled && held_pattern == 8'd0))
    else $error("timeout did not disable drive state");

  a_quiet_phases: assert property (@(posedge clk) disable iff (rst)
    (accept && (phase_c == PH_TIMEOUT || phase_c == PH_IDLE))
      |=> (out_data.drive == 8'd0))
    else $error("drive active in idle or timed out phase");

endmodule
